[hdl/rlhi_pkg.sv]
// ----------------------------------------------------------------------------
// rlhi_pkg
// Shared types and constants of the row location hash index.
// ----------------------------------------------------------------------------
`default_nettype none

package rlhi_pkg;

  localparam int unsigned DefTableSlots = 512;

  localparam int unsigned PageW  = 32;
  localparam int unsigned RowW   = 32;
  localparam int unsigned ValueW = 8;
  localparam int unsigned HashW  = 32;

  localparam logic [HashW-1:0] HashMulPage = 32'd2654435761;
  localparam logic [15:0]      HashMulRow  = 16'd40503;
  localparam int unsigned      HashFold    = 13;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncLookup = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StFold,
    StMod,
    StRead,
    StCheck,
    StOut
  } state_e;

  typedef struct packed {
    logic              used;
    logic [PageW-1:0]  page;
    logic [RowW-1:0]   row;
    logic [ValueW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic fold;
    logic mod_step;
    logic clr_wr;
    logic clr_step;
    logic probe_step;
    logic ins_wr;
    logic res_load;
    logic res_hit;
    logic res_val;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic func_lookup;
    logic slot_used;
    logic key_match;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/rlhi_ctrl.sv]
// ----------------------------------------------------------------------------
// rlhi_ctrl
// Controller: clear sweep, hash sequencing, probe decisions and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rlhi_ctrl #(
  parameter int unsigned TABLE_SLOTS = rlhi_pkg::DefTableSlots
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_tvalid_i,
  output logic                   s_tready_o,
  input  wire rlhi_pkg::sts_t    sts_i,
  output rlhi_pkg::cmd_t         cmd_o
);

  localparam bit IsPow2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  rlhi_pkg::state_e state_q, state_d;
  logic in_fire;

  assign s_tready_o = (state_q == rlhi_pkg::StIdle);
  assign in_fire    = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlhi_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlhi_pkg::StClear: if (sts_i.clr_last) state_d = rlhi_pkg::StIdle;
      rlhi_pkg::StIdle:  if (in_fire) state_d = rlhi_pkg::StMul;
      rlhi_pkg::StMul:   state_d = rlhi_pkg::StFold;
      rlhi_pkg::StFold:  state_d = IsPow2 ? rlhi_pkg::StRead : rlhi_pkg::StMod;
      rlhi_pkg::StMod:   if (sts_i.mod_last) state_d = rlhi_pkg::StRead;
      rlhi_pkg::StRead:  state_d = rlhi_pkg::StCheck;
      rlhi_pkg::StCheck: begin
        if (!sts_i.slot_used || sts_i.probe_last ||
            (sts_i.func_lookup && sts_i.key_match)) begin
          state_d = rlhi_pkg::StOut;
        end else begin
          state_d = rlhi_pkg::StRead;
        end
      end
      rlhi_pkg::StOut:   if (sts_i.out_free) state_d = rlhi_pkg::StIdle;
      default:           state_d = rlhi_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      rlhi_pkg::StClear: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.clr_step = 1'b1;
      end
      rlhi_pkg::StIdle:  cmd_o.load_in = in_fire;
      rlhi_pkg::StMul:   cmd_o.mul = 1'b1;
      rlhi_pkg::StFold:  cmd_o.fold = 1'b1;
      rlhi_pkg::StMod:   cmd_o.mod_step = 1'b1;
      rlhi_pkg::StRead:  cmd_o = '0;
      rlhi_pkg::StCheck: begin
        if (!sts_i.slot_used) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = !sts_i.func_lookup;
          cmd_o.ins_wr   = !sts_i.func_lookup;
        end else if (sts_i.func_lookup && sts_i.key_match) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = 1'b1;
          cmd_o.res_val  = 1'b1;
        end else if (sts_i.probe_last) begin
          cmd_o.res_load = 1'b1;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      rlhi_pkg::StOut:   cmd_o.out_load = sts_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

  a_ins_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins_wr |-> !sts_i.slot_used && !sts_i.func_lookup)
    else $error("insert written over a used slot");

  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == rlhi_pkg::StMul)
    else $error("accepted beat not hashed");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result overwrote a pending beat");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlhi_pkg::StClear && sts_i.clr_last) |=> state_q == rlhi_pkg::StIdle)
    else $error("clear sweep did not finish");

endmodule

`default_nettype wire

[hdl/rlhi_dpath.sv]
// ----------------------------------------------------------------------------
// rlhi_dpath
// Datapath: input hold, hash, slot reduction, slot memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlhi_dpath #(
  parameter int unsigned TABLE_SLOTS = rlhi_pkg::DefTableSlots
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               func_i,
  input  wire [rlhi_pkg::PageW-1:0]         page_i,
  input  wire [rlhi_pkg::RowW-1:0]          row_i,
  input  wire [rlhi_pkg::ValueW-1:0]        value_i,
  input  wire rlhi_pkg::cmd_t               cmd_i,
  output rlhi_pkg::sts_t                    sts_o,
  output logic                              m_tvalid_o,
  input  wire                               m_tready_i,
  output logic                              hit_o,
  output logic [rlhi_pkg::ValueW-1:0]       found_o
);

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_SLOTS - 1);
  localparam logic [AW:0]   SlotsExt = (AW+1)'(TABLE_SLOTS);
  localparam logic [rlhi_pkg::HashW-1:0] RecipM =
    32'((64'd1 << rlhi_pkg::HashW) / 64'(TABLE_SLOTS));

  logic                        func_q;
  logic [rlhi_pkg::PageW-1:0]  page_q;
  logic [rlhi_pkg::RowW-1:0]   row_q;
  logic [rlhi_pkg::ValueW-1:0] value_q;
  logic [rlhi_pkg::HashW-1:0]  prod_a_q, prod_b_q, hash_q, hash_d;
  logic [rlhi_pkg::HashW-1:0]  quot_q, quot_d;
  logic [2*rlhi_pkg::HashW-1:0] recip_prod;
  logic [AW-1:0]               addr_q, addr_d, cnt_q, cnt_d;
  logic                        mod_cnt_q, mod_cnt_d;
  logic [AW:0]                 qn_low, rem_est, rem_sub;
  logic [AW-1:0]               addr_next;

  rlhi_pkg::entry_t mem_q [TABLE_SLOTS];
  rlhi_pkg::entry_t rd_q, wr_data;
  logic             wr_en;

  logic m_tvalid_q, m_tvalid_d, hit_q, res_hit_q, res_hit_d;
  logic [rlhi_pkg::ValueW-1:0] found_q, res_val_q, res_val_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= func_i;
      page_q  <= page_i;
      row_q   <= row_i;
      value_q <= value_i;
    end
    if (cmd_i.mul) begin
      prod_a_q <= 32'(page_q * rlhi_pkg::HashMulPage);
      prod_b_q <= 32'(row_q * 32'(rlhi_pkg::HashMulRow));
    end
  end

  assign addr_next  = (addr_q == LastSlot) ? '0 : addr_q + AW'(1);
  assign recip_prod = 64'(hash_q) * 64'(RecipM);
  assign qn_low     = (AW+1)'(quot_q[AW:0] * SlotsExt);
  assign rem_est    = hash_q[AW:0] - qn_low;
  assign rem_sub    = (rem_est >= SlotsExt) ? rem_est - SlotsExt : rem_est;

  always_comb begin
    hash_d    = hash_q;
    quot_d    = quot_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    mod_cnt_d = mod_cnt_q;
    if (cmd_i.fold) begin
      hash_d    = (prod_a_q ^ prod_b_q) ^ ((prod_a_q ^ prod_b_q) >> rlhi_pkg::HashFold);
      addr_d    = hash_d[AW-1:0];
      if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) != 0) begin
        addr_d = '0;
      end
      cnt_d     = '0;
      mod_cnt_d = 1'b0;
    end else if (cmd_i.mod_step) begin
      if (!mod_cnt_q) begin
        quot_d = recip_prod[2*rlhi_pkg::HashW-1:rlhi_pkg::HashW];
      end else begin
        addr_d = rem_sub[AW-1:0];
      end
      mod_cnt_d = !mod_cnt_q;
    end else if (cmd_i.clr_step || cmd_i.probe_step) begin
      addr_d = addr_next;
      cnt_d  = cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q    <= hash_d;
    quot_q    <= quot_d;
    cnt_q     <= cnt_d;
    mod_cnt_q <= mod_cnt_d;
  end

  always_comb begin
    wr_en         = cmd_i.clr_wr || cmd_i.ins_wr;
    wr_data.used  = cmd_i.ins_wr;
    wr_data.page  = page_q;
    wr_data.row   = row_q;
    wr_data.value = value_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= wr_data;
    end
    rd_q <= mem_q[addr_q];
  end

  assign res_hit_d = cmd_i.res_load ? cmd_i.res_hit : res_hit_q;
  assign res_val_d = cmd_i.res_load ? (cmd_i.res_val ? rd_q.value : '0) : res_val_q;

  always_ff @(posedge clk_i) begin
    res_hit_q <= res_hit_d;
    res_val_q <= res_val_d;
    if (cmd_i.out_load) begin
      hit_q   <= res_hit_q;
      found_q <= res_val_q;
    end
  end

  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (cmd_i.out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign hit_o      = hit_q;
  assign found_o    = found_q;

  always_comb begin
    sts_o.clr_last    = (addr_q == LastSlot);
    sts_o.mod_last    = mod_cnt_q;
    sts_o.func_lookup = (func_q == rlhi_pkg::FuncLookup);
    sts_o.slot_used   = rd_q.used;
    sts_o.key_match   = (rd_q.page == page_q) && (rd_q.row == row_q);
    sts_o.probe_last  = (cnt_q == LastSlot);
    sts_o.out_free    = !m_tvalid_q || m_tready_i;
  end

endmodule

`default_nettype wire

[hdl/row_location_hash_index.sv]
// ----------------------------------------------------------------------------
// row_location_hash_index
// Insert-only open-addressed hash table with linear probing, keyed by
// (page number, row in page) and holding an 8-bit version index.
//
//   port group  dir  tdata                                  tuser
//   s_axis      in   page_number, row_in_page, entry_value  func
//   m_axis      out  found_value                            hit
//
// Each beat is hashed (multiply, fold) and then probed; each probe is one read
// of the slot memory and one compare. The next beat is taken in the cycle after
// the result is loaded, so beats never overlap. A table size other than a power
// of two adds the reciprocal slot reduction, a quotient step then a remainder
// step. After reset the slot memory is swept, one slot a cycle, over every slot
// before the first beat is taken. A new beat is taken while a result waits on
// m_axis; the next result holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module row_location_hash_index #(
  parameter int unsigned TABLE_SLOTS = rlhi_pkg::DefTableSlots
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire [71:0]  s_axis_tdata_i,   // page_number, row_in_page, entry_value
  input  wire         s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // found_value
  output logic        m_axis_tuser_o    // hit
);

  rlhi_pkg::cmd_t cmd;
  rlhi_pkg::sts_t sts;

  rlhi_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlhi_dpath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .func_i     (s_axis_tuser_i),
    .page_i     (s_axis_tdata_i[31:0]),
    .row_i      (s_axis_tdata_i[63:32]),
    .value_i    (s_axis_tdata_i[71:64]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .hit_o      (m_axis_tuser_o),
    .found_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[tb/sv/row_index_checker.sv]
// ----------------------------------------------------------------------------
// row_index_checker
// Watches both stream channels of the row location hash index. Keeps its own
// copy of the slot table, predicts hit and found_value for every request beat
// and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module row_index_checker #(
  parameter int unsigned Slots = rlhi_pkg::DefTableSlots
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  input  wire         s_axis_tready_i,
  input  wire  [71:0] s_axis_tdata_i,   // page_number, row_in_page, entry_value
  input  wire         s_axis_tuser_i,   // func
  input  wire         m_axis_tvalid_i,
  input  wire         m_axis_tready_i,
  input  wire  [7:0]  m_axis_tdata_i,   // found_value
  input  wire         m_axis_tuser_i,   // hit
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        hit;
    logic [rlhi_pkg::ValueW-1:0] value;
  } answer_t;

  answer_t                     answer_q[$];
  logic                        used_map  [Slots];
  logic [rlhi_pkg::PageW-1:0]  page_map  [Slots];
  logic [rlhi_pkg::RowW-1:0]   row_map   [Slots];
  logic [rlhi_pkg::ValueW-1:0] value_map [Slots];
  int                          error_cnt;
  int                          pending_cnt;

  assign errors_o  = error_cnt;
  assign pending_o = pending_cnt;

  initial begin
    error_cnt   = 0;
    pending_cnt = 0;
    for (int i = 0; i < Slots; i++) begin
      used_map[i] = 1'b0;
    end
  end

  function automatic int unsigned hash_home(input logic [rlhi_pkg::PageW-1:0] pg,
                                            input logic [rlhi_pkg::RowW-1:0]  rw);
    logic [rlhi_pkg::HashW-1:0] h;
    h = (pg * rlhi_pkg::HashMulPage) ^ (rw * rlhi_pkg::HashMulRow);
    h = h ^ (h >> rlhi_pkg::HashFold);
    return h % Slots;
  endfunction

  function automatic answer_t probe_table(input logic                        fn,
                                          input logic [rlhi_pkg::PageW-1:0]  pg,
                                          input logic [rlhi_pkg::RowW-1:0]   rw,
                                          input logic [rlhi_pkg::ValueW-1:0] v);
    answer_t     ans;
    int unsigned home;
    int unsigned s;
    ans  = '0;
    home = hash_home(pg, rw);
    for (int unsigned p = 0; p < Slots; p++) begin
      s = (home + p) % Slots;
      if (fn == rlhi_pkg::FuncInsert) begin
        if (!used_map[s]) begin
          used_map[s]  = 1'b1;
          page_map[s]  = pg;
          row_map[s]   = rw;
          value_map[s] = v;
          ans.hit      = 1'b1;
          break;
        end
      end else begin
        if (!used_map[s]) break;
        if (page_map[s] == pg && row_map[s] == rw) begin
          ans.hit   = 1'b1;
          ans.value = value_map[s];
          break;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin : watch
    answer_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (answer_q.size() == 0) begin
          $error("result beat with nothing expected: hit %0b found_value %0h",
                 m_axis_tuser_i, m_axis_tdata_i);
          error_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tuser_i !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, m_axis_tuser_i);
            error_cnt++;
          end
          if (m_axis_tdata_i !== want.value) begin
            $error("found_value: expected %0h, got %0h", want.value, m_axis_tdata_i);
            error_cnt++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        answer_q.push_back(probe_table(s_axis_tuser_i, s_axis_tdata_i[31:0],
                                       s_axis_tdata_i[63:32], s_axis_tdata_i[71:64]));
      end
      pending_cnt = answer_q.size();
    end
  end

  final begin
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives insert and lookup beats into the row location hash index: a short
// directed pass over key extremes and duplicates, then random traffic that
// fills the table past full, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1925;
  localparam int FillItems   = 1300;
  localparam int TailCycles  = 64;
  localparam longint CycleLimit = 10_000_000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  wire         s_axis_tready_o;
  logic [71:0] s_axis_tdata_i  = '0;  // page_number, row_in_page, entry_value
  logic        s_axis_tuser_i  = 1'b0; // func
  wire         m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  wire  [7:0]  m_axis_tdata_o;        // found_value
  wire         m_axis_tuser_o;        // hit

  int          errors;
  int          pending;
  logic        idle_on = 1'b1;
  longint      cycles  = 0;
  logic [63:0] key_q[$];

  always #5 clk_i = ~clk_i;

  row_location_hash_index u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  row_index_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic fn, input logic [31:0] pg, input logic [31:0] rw,
                           input logic [7:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {v, rw, pg};
    s_axis_tuser_i  <= fn;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 63);
      default: return $urandom();
    endcase
  endfunction

  initial begin : result_sink
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin : stimulus
    logic [63:0] key;
    int          sel;
    int          ins_pct;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(rlhi_pkg::FuncLookup, '0, '0, 8'hFF);
    send_beat(rlhi_pkg::FuncInsert, '0, '0, 8'h00);
    send_beat(rlhi_pkg::FuncInsert, '1, '1, 8'hFF);
    send_beat(rlhi_pkg::FuncLookup, '0, '0, 8'h00);
    send_beat(rlhi_pkg::FuncLookup, '1, '1, 8'h00);
    send_beat(rlhi_pkg::FuncInsert, '0, '0, 8'hA5);
    send_beat(rlhi_pkg::FuncLookup, '0, '0, 8'h5A);
    send_beat(rlhi_pkg::FuncLookup, 32'h0, 32'h1, 8'h00);
    send_beat(rlhi_pkg::FuncInsert, 32'h8000_0000, 32'h0000_0001, 8'h5A);
    send_beat(rlhi_pkg::FuncInsert, 32'h0000_0001, 32'h8000_0000, 8'h3C);
    send_beat(rlhi_pkg::FuncLookup, 32'h8000_0000, 32'h0000_0001, 8'hFF);
    send_beat(rlhi_pkg::FuncLookup, 32'h0000_0001, 32'h8000_0000, 8'h00);
    send_beat(rlhi_pkg::FuncInsert, '1, '0, 8'h81);
    send_beat(rlhi_pkg::FuncInsert, '0, '1, 8'h7E);
    send_beat(rlhi_pkg::FuncLookup, '1, '0, 8'h00);
    send_beat(rlhi_pkg::FuncLookup, '0, '1, 8'h00);
    send_beat(rlhi_pkg::FuncLookup, '1, 32'hFFFF_FFFE, 8'h00);
    send_beat(rlhi_pkg::FuncInsert, '1, '1, 8'h01);
    send_beat(rlhi_pkg::FuncLookup, '1, '1, 8'h00);
    key_q.push_back(64'h0);
    key_q.push_back('1);
    key_q.push_back({32'h0000_0001, 32'h8000_0000});
    key_q.push_back({32'h8000_0000, 32'h0000_0001});

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      ins_pct = (n < FillItems) ? 45 : 10;
      if ($urandom_range(0, 99) < ins_pct) begin
        if ($urandom_range(0, 4) == 0) begin
          key = key_q[$urandom_range(0, key_q.size() - 1)];
        end else begin
          key = {pick_word(), pick_word()};
          key_q.push_back(key);
        end
        send_beat(rlhi_pkg::FuncInsert, key[31:0], key[63:32], 8'($urandom_range(0, 255)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          key = {pick_word(), pick_word()};
        end else begin
          key = key_q[$urandom_range(0, key_q.size() - 1)];
          if (sel < 35) key = key ^ (64'd1 << $urandom_range(0, 63));
        end
        send_beat(rlhi_pkg::FuncLookup, key[31:0], key[63:32], 8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rlhi_pkg.sv
hdl/rlhi_ctrl.sv
hdl/rlhi_dpath.sv
hdl/row_location_hash_index.sv
tb/sv/row_index_checker.sv
tb/sv/tb.sv
